[hw/rtl/ofp_pkg.sv]
// ----------------------------------------------------------------------------
// ofp_pkg
// Shared types, codes and decode table for the order feed message parser.
// ----------------------------------------------------------------------------
package ofp_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int IDXW   = 6;
    localparam int TDATAW = 264;

    localparam logic [7:0] CH_ADD       = 8'h41;
    localparam logic [7:0] CH_ADD_ATTR  = 8'h46;
    localparam logic [7:0] CH_EXEC      = 8'h45;
    localparam logic [7:0] CH_EXEC_PX   = 8'h43;
    localparam logic [7:0] CH_CANCEL    = 8'h58;
    localparam logic [7:0] CH_DELETE    = 8'h44;
    localparam logic [7:0] CH_REPLACE   = 8'h55;
    localparam logic [7:0] CH_BUY       = 8'h42;

    typedef enum logic [2:0] {
        KIND_ADD        = 3'd0,
        KIND_EXEC       = 3'd1,
        KIND_EXEC_PRICE = 3'd2,
        KIND_CANCEL     = 3'd3,
        KIND_DELETE     = 3'd4,
        KIND_REPLACE    = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        PFX_HI   = 2'd0,
        PFX_LO   = 2'd1,
        PFX_BODY = 2'd2
    } pfx_state_t;

    // one body byte, tagged by the front end
    typedef struct packed {
        logic [7:0]      data;
        logic [IDXW-1:0] idx;   // body offset, saturated
        logic            last;
    } tok_t;

    typedef struct packed {
        logic            known;
        kind_t           kind;
        logic [IDXW-1:0] last_idx;  // offset of the last field byte
    } dec_t;

    function automatic dec_t decode_type(input logic [7:0] t);
        dec_t d;
        d.known    = 1'b1;
        d.kind     = KIND_ADD;
        d.last_idx = 6'd35;
        case (t)
            CH_ADD, CH_ADD_ATTR: begin d.kind = KIND_ADD;        d.last_idx = 6'd35; end
            CH_EXEC:             begin d.kind = KIND_EXEC;       d.last_idx = 6'd22; end
            CH_EXEC_PX:          begin d.kind = KIND_EXEC_PRICE; d.last_idx = 6'd35; end
            CH_CANCEL:           begin d.kind = KIND_CANCEL;     d.last_idx = 6'd22; end
            CH_DELETE:           begin d.kind = KIND_DELETE;     d.last_idx = 6'd18; end
            CH_REPLACE:          begin d.kind = KIND_REPLACE;    d.last_idx = 6'd34; end
            default:             d.known = 1'b0;
        endcase
        return d;
    endfunction

endpackage

[hw/rtl/ofp_front.sv]
// ----------------------------------------------------------------------------
// ofp_front
// Length-prefix framer: strips the prefix and tags each body byte.
// ----------------------------------------------------------------------------
module ofp_front
    import ofp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,
    input  logic       q_full,
    output logic       q_push,
    output tok_t       q_tok
);

    pfx_state_t  state_reg, state_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] idx_reg, idx_next;
    logic        acc;
    logic        last;

    assign s_axis_tready = !q_full;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign last          = (idx_reg + 16'd1) == len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PFX_HI;
            len_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        q_push     = 1'b0;
        q_tok.data = s_axis_tdata;
        q_tok.idx  = (|idx_reg[15:IDXW]) ? {IDXW{1'b1}} : idx_reg[IDXW-1:0];
        q_tok.last = last;
        if (acc)
        begin
            case (state_reg)
                PFX_HI:
                begin
                    len_next   = {8'h00, s_axis_tdata};
                    state_next = PFX_LO;
                end
                PFX_LO:
                begin
                    len_next   = {len_reg[7:0], s_axis_tdata};
                    idx_next   = '0;
                    state_next = ({len_reg[7:0], s_axis_tdata} == 16'd0) ? PFX_HI : PFX_BODY;
                end
                PFX_BODY:
                begin
                    q_push   = 1'b1;
                    idx_next = idx_reg + 16'd1;
                    if (last)
                        state_next = PFX_HI;
                end
                default:
                    state_next = PFX_HI;
            endcase
        end
    end

endmodule

[hw/rtl/ofp_queue.sv]
// ----------------------------------------------------------------------------
// ofp_queue
// Small token FIFO between framer and field decoder.
// ----------------------------------------------------------------------------
module ofp_queue
    import ofp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  tok_t push_tok,
    output logic full,
    input  logic pop,
    output logic nonempty,
    output tok_t pop_tok
);

    tok_t             mem [QDEPTH];
    logic [QAW-1:0]   wr_reg, rd_reg;
    logic [QAW:0]     cnt_reg, cnt_next;

    assign full     = cnt_reg == QDEPTH[QAW:0];
    assign nonempty = cnt_reg != '0;
    assign pop_tok  = mem[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_tok;
    end

endmodule

[hw/rtl/ofp_back.sv]
// ----------------------------------------------------------------------------
// ofp_back
// Field capture per message type and event output register.
// ----------------------------------------------------------------------------
module ofp_back
    import ofp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_nonempty,
    input  tok_t              q_tok,
    output logic              q_pop,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [TDATAW-1:0] m_axis_tdata,   // order_ref, replacement_ref, is_buy,
                                              // share_count, stock_symbol, limit_price
    output logic [2:0]        m_axis_tuser    // event_kind
);

    logic [7:0]  type_reg, type_next;
    logic [63:0] ref_reg, ref_next;
    logic [63:0] nref_reg, nref_next;
    logic [31:0] qty_reg, qty_next;
    logic [63:0] sym_reg, sym_next;
    logic [31:0] px_reg, px_next;
    logic        side_reg, side_next;

    logic              vld_reg, vld_next;
    logic [TDATAW-1:0] data_reg;
    kind_t             kind_reg;

    logic            first;
    logic [7:0]      b;
    logic [5:0]      i;
    logic            is_add, is_exq, is_rep;
    dec_t            dec;
    logic            emit;
    logic [63:0]     o_nref, o_sym;
    logic [31:0]     o_qty, o_px;
    logic            o_buy;

    assign q_pop  = q_nonempty && (!vld_reg || m_axis_tready);
    assign b      = q_tok.data;
    assign i      = q_tok.idx;
    assign first  = i == '0;

    always_comb
    begin
        type_next = first ? b : type_reg;
        ref_next  = first ? '0 : ref_reg;
        nref_next = first ? '0 : nref_reg;
        qty_next  = first ? '0 : qty_reg;
        sym_next  = first ? '0 : sym_reg;
        px_next   = first ? '0 : px_reg;
        side_next = first ? 1'b0 : side_reg;

        is_add = (type_next == CH_ADD) || (type_next == CH_ADD_ATTR);
        is_exq = (type_next == CH_EXEC) || (type_next == CH_CANCEL)
              || (type_next == CH_EXEC_PX);
        is_rep = type_next == CH_REPLACE;

        if (i >= 6'd11 && i <= 6'd18)
            ref_next = {ref_next[55:0], b};
        if (is_add)
        begin
            if (i == 6'd19)
                side_next = b == CH_BUY;
            if (i >= 6'd20 && i <= 6'd23)
                qty_next = {qty_next[23:0], b};
            if (i >= 6'd24 && i <= 6'd31)
                sym_next = {sym_next[55:0], b};
            if (i >= 6'd32 && i <= 6'd35)
                px_next = {px_next[23:0], b};
        end
        else if (is_exq)
        begin
            if (i >= 6'd19 && i <= 6'd22)
                qty_next = {qty_next[23:0], b};
            if (type_next == CH_EXEC_PX && i >= 6'd32 && i <= 6'd35)
                px_next = {px_next[23:0], b};
        end
        else if (is_rep)
        begin
            if (i >= 6'd19 && i <= 6'd26)
                nref_next = {nref_next[55:0], b};
            if (i >= 6'd27 && i <= 6'd30)
                qty_next = {qty_next[23:0], b};
            if (i >= 6'd31 && i <= 6'd34)
                px_next = {px_next[23:0], b};
        end

        dec  = decode_type(type_next);
        emit = q_pop && q_tok.last && dec.known && (i >= dec.last_idx);

        o_nref = (dec.kind == KIND_REPLACE) ? nref_next : '0;
        o_buy  = (dec.kind == KIND_ADD) ? side_next : 1'b0;
        o_qty  = (dec.kind == KIND_DELETE) ? '0 : qty_next;
        o_sym  = (dec.kind == KIND_ADD) ? sym_next : '0;
        o_px   = (dec.kind == KIND_ADD || dec.kind == KIND_EXEC_PRICE
               || dec.kind == KIND_REPLACE) ? px_next : '0;

        vld_next = emit ? 1'b1 : (m_axis_tready ? 1'b0 : vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= 1'b0;
            type_reg <= '0;
            ref_reg  <= '0;
            nref_reg <= '0;
            qty_reg  <= '0;
            sym_reg  <= '0;
            px_reg   <= '0;
            side_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (q_pop)
            begin
                type_reg <= type_next;
                ref_reg  <= ref_next;
                nref_reg <= nref_next;
                qty_reg  <= qty_next;
                sym_reg  <= sym_next;
                px_reg   <= px_next;
                side_reg <= side_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg <= dec.kind;
            data_reg <= {7'd0, o_px, o_sym, o_qty, o_buy, o_nref, ref_next};
        end
    end

    assign m_axis_tvalid = vld_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tuser  = kind_reg;

endmodule

[hw/rtl/order_feed_message_parser_top.sv]
// ----------------------------------------------------------------------------
// order_feed_message_parser_top
// Decodes a length-prefixed order feed byte stream into order events.
//
//  channel   dir  payload                                         transfer
//  s_axis    in   tdata[7:0] data_byte                            tvalid & tready
//  m_axis    out  tuser event_kind; tdata order_ref .. limit_price tvalid & tready
//
//  One byte per cycle; a 4-entry token queue parts the framer from the decoder.
//  Once the decoder pops an event's last body byte from the queue, the event is
//  registered, raising tvalid, in a one-entry output register until its own transfer.
//  Reset clears framing state, capture registers and queue; no clearing pass.
//  An output stall holds the decoder; input stalls once the queue fills.
// ----------------------------------------------------------------------------
module order_feed_message_parser_top
    import ofp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // data_byte
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [TDATAW-1:0] m_axis_tdata,   // order_ref[63:0], replacement_ref[127:64],
                                              // is_buy[128], share_count[160:129],
                                              // stock_symbol[224:161], limit_price[256:225]
    output logic [2:0]        m_axis_tuser    // event_kind
);

    logic q_push, q_full, q_pop, q_nonempty;
    tok_t q_in, q_out;

    ofp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_tok         (q_in)
    );

    ofp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_tok (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .nonempty (q_nonempty),
        .pop_tok  (q_out)
    );

    ofp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_nonempty    (q_nonempty),
        .q_tok         (q_out),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_nonempty)
        else $error("pop from empty queue");

    a_add_only_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != KIND_ADD)
            |-> (m_axis_tdata[128] == 1'b0 && m_axis_tdata[224:161] == '0))
        else $error("add-only fields set on non-add event");

    a_stall_holds_decoder: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !q_pop)
        else $error("decoder advanced while output stalled");

endmodule

[dv/tb_order_feed_message_parser_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_order_feed_message_parser_top
// Drives length-prefixed order feed messages into the parser one byte per
// transfer and compares every decoded order event against a listed expected event
// or a built-in decoder model. A directed message table comes first, then random
// framed messages with noise, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module tb_order_feed_message_parser_top;
    import ofp_pkg::*;

    typedef struct {
        kind_t       kind;
        logic [63:0] order_ref;
        logic [63:0] replacement_ref;
        logic        is_buy;
        logic [31:0] share_count;
        logic [63:0] stock_symbol;
        logic [31:0] limit_price;
    } order_event_t;

    typedef enum {FILL_CONST, FILL_RAND, FILL_RAMP} fill_t;
    typedef enum {CHK_MODEL, CHK_NONE, CHK_LISTED} chk_t;

    typedef struct {
        logic [7:0]   mtype;
        logic [15:0]  blen;
        fill_t        fill;
        logic [7:0]   fval;
        chk_t         chk;
        order_event_t listed;
    } msg_row_t;

    localparam logic [63:0] ALL64 = '1;
    localparam logic [31:0] ALL32 = '1;
    localparam logic [63:0] B64   = {8{CH_BUY}};
    localparam logic [31:0] B32   = {4{CH_BUY}};
    localparam int          NROWS = 23;

    logic               clk;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = 8'h00;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATAW-1:0]  m_axis_tdata;
    logic [2:0]         m_axis_tuser;

    // decoder model state
    pfx_state_t  frame_st = PFX_HI;
    logic [15:0] body_len = '0;
    logic [15:0] body_idx = '0;
    logic [7:0]  msg_type = '0;
    logic [63:0] ref_sh = '0;
    logic [63:0] new_ref_sh = '0;
    logic [31:0] qty_sh = '0;
    logic [63:0] sym_sh = '0;
    logic [31:0] px_sh = '0;
    logic        side_b = 1'b0;

    order_event_t pending_events[$];
    int           mismatch_count = 0;
    int           rand_bytes = 0;
    bit           quiet_phase = 1'b0;
    bit           src_calm = 1'b0;
    bit           sink_calm = 1'b0;
    int           sink_hold = 0;

    logic [7:0] known_types[7] = '{CH_ADD, CH_ADD_ATTR, CH_EXEC, CH_EXEC_PX,
                                   CH_CANCEL, CH_DELETE, CH_REPLACE};
    string      fld_name[7] = '{"event_kind", "order_ref", "replacement_ref", "is_buy",
                                "share_count", "stock_symbol", "limit_price"};

    localparam order_event_t NO_EVENT = '{KIND_ADD, '0, '0, '0, '0, '0, '0};

    msg_row_t dir_rows[NROWS] = '{
        '{CH_ADD,      16'd36, FILL_CONST, 8'hFF, CHK_LISTED,
          '{KIND_ADD, ALL64, '0, 1'b0, ALL32, ALL64, ALL32}},
        '{CH_ADD_ATTR, 16'd36, FILL_CONST, 8'h00, CHK_LISTED,
          '{KIND_ADD, '0, '0, 1'b0, '0, '0, '0}},
        '{CH_ADD,      16'd36, FILL_CONST, CH_BUY, CHK_LISTED,
          '{KIND_ADD, B64, '0, 1'b1, B32, B64, B32}},
        '{CH_EXEC,     16'd23, FILL_CONST, 8'hFF, CHK_LISTED,
          '{KIND_EXEC, ALL64, '0, 1'b0, ALL32, '0, '0}},
        '{CH_EXEC_PX,  16'd36, FILL_CONST, 8'hFF, CHK_LISTED,
          '{KIND_EXEC_PRICE, ALL64, '0, 1'b0, ALL32, '0, ALL32}},
        '{CH_CANCEL,   16'd23, FILL_CONST, 8'hFF, CHK_LISTED,
          '{KIND_CANCEL, ALL64, '0, 1'b0, ALL32, '0, '0}},
        '{CH_DELETE,   16'd19, FILL_CONST, 8'hFF, CHK_LISTED,
          '{KIND_DELETE, ALL64, '0, 1'b0, '0, '0, '0}},
        '{CH_REPLACE,  16'd35, FILL_CONST, 8'hFF, CHK_LISTED,
          '{KIND_REPLACE, ALL64, ALL64, 1'b0, ALL32, '0, ALL32}},
        // too short for the last field
        '{CH_ADD,      16'd35, FILL_CONST, 8'hFF, CHK_NONE, NO_EVENT},
        '{CH_EXEC,     16'd22, FILL_CONST, 8'hFF, CHK_NONE, NO_EVENT},
        '{CH_CANCEL,   16'd22, FILL_CONST, 8'hFF, CHK_NONE, NO_EVENT},
        '{CH_EXEC_PX,  16'd35, FILL_CONST, 8'hFF, CHK_NONE, NO_EVENT},
        '{CH_DELETE,   16'd18, FILL_CONST, 8'hFF, CHK_NONE, NO_EVENT},
        '{CH_REPLACE,  16'd34, FILL_CONST, 8'hFF, CHK_NONE, NO_EVENT},
        '{CH_ADD_ATTR, 16'd1,  FILL_CONST, 8'hFF, CHK_NONE, NO_EVENT},
        // empty body, then unknown types
        '{8'h00,       16'd0,  FILL_CONST, 8'hFF, CHK_NONE, NO_EVENT},
        '{8'h00,       16'd40, FILL_CONST, 8'hFF, CHK_NONE, NO_EVENT},
        '{8'hFF,       16'd5,  FILL_CONST, 8'hFF, CHK_NONE, NO_EVENT},
        // ramp and random fills checked against the model, most with long bodies
        '{CH_REPLACE,  16'd60,     FILL_RAND, 8'h00, CHK_MODEL, NO_EVENT},
        '{CH_EXEC_PX,  16'd37,     FILL_RAMP, 8'h00, CHK_MODEL, NO_EVENT},
        '{CH_EXEC,     16'd23,     FILL_RAMP, 8'h00, CHK_MODEL, NO_EVENT},
        '{CH_DELETE,   16'h0100,   FILL_RAMP, 8'h00, CHK_MODEL, NO_EVENT},
        '{CH_ADD,      16'd80,     FILL_RAND, 8'h00, CHK_MODEL, NO_EVENT}
    };

    order_feed_message_parser_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("status: fail");
        $finish;
    end

    // minimum body length for a known type, 0 for unknown
    function automatic int min_body(input logic [7:0] t);
        case (t)
            CH_ADD, CH_ADD_ATTR, CH_EXEC_PX: return 36;
            CH_EXEC, CH_CANCEL:              return 23;
            CH_DELETE:                       return 19;
            CH_REPLACE:                      return 35;
            default:                         return 0;
        endcase
    endfunction

    function automatic bit decode_feed_byte(input logic [7:0] b, output order_event_t ev);
        int    k;
        int    need;
        bit    is_add;
        bit    is_qty;
        kind_t kind;
        if (frame_st == PFX_HI)
        begin
            body_len = {8'h00, b};
            frame_st = PFX_LO;
            return 1'b0;
        end
        if (frame_st == PFX_LO)
        begin
            body_len = {body_len[7:0], b};
            body_idx = '0;
            frame_st = (body_len == 16'd0) ? PFX_HI : PFX_BODY;
            return 1'b0;
        end
        if (body_idx == 16'd0)
        begin
            msg_type   = b;
            ref_sh     = '0;
            new_ref_sh = '0;
            qty_sh     = '0;
            sym_sh     = '0;
            px_sh      = '0;
            side_b     = 1'b0;
        end
        k      = body_idx;
        is_add = (msg_type == CH_ADD) || (msg_type == CH_ADD_ATTR);
        is_qty = (msg_type == CH_EXEC) || (msg_type == CH_CANCEL) || (msg_type == CH_EXEC_PX);
        if (k >= 11 && k < 19)
            ref_sh = {ref_sh[55:0], b};
        if (is_add)
        begin
            if (k == 19)
                side_b = (b == CH_BUY);
            if (k >= 20 && k < 24)
                qty_sh = {qty_sh[23:0], b};
            if (k >= 24 && k < 32)
                sym_sh = {sym_sh[55:0], b};
            if (k >= 32 && k < 36)
                px_sh = {px_sh[23:0], b};
        end
        else if (is_qty)
        begin
            if (k >= 19 && k < 23)
                qty_sh = {qty_sh[23:0], b};
            if (msg_type == CH_EXEC_PX && k >= 32 && k < 36)
                px_sh = {px_sh[23:0], b};
        end
        else if (msg_type == CH_REPLACE)
        begin
            if (k >= 19 && k < 27)
                new_ref_sh = {new_ref_sh[55:0], b};
            if (k >= 27 && k < 31)
                qty_sh = {qty_sh[23:0], b};
            if (k >= 31 && k < 35)
                px_sh = {px_sh[23:0], b};
        end
        body_idx = body_idx + 16'd1;
        if (body_idx < body_len)
            return 1'b0;
        frame_st = PFX_HI;
        need = min_body(msg_type);
        if (need == 0 || body_len < need)
            return 1'b0;
        case (msg_type)
            CH_EXEC:    kind = KIND_EXEC;
            CH_EXEC_PX: kind = KIND_EXEC_PRICE;
            CH_CANCEL:  kind = KIND_CANCEL;
            CH_DELETE:  kind = KIND_DELETE;
            CH_REPLACE: kind = KIND_REPLACE;
            default:    kind = KIND_ADD;
        endcase
        ev.kind            = kind;
        ev.order_ref       = ref_sh;
        ev.replacement_ref = (kind == KIND_REPLACE) ? new_ref_sh : '0;
        ev.is_buy          = (kind == KIND_ADD) ? side_b : 1'b0;
        ev.share_count     = (kind == KIND_DELETE) ? '0 : qty_sh;
        ev.stock_symbol    = (kind == KIND_ADD) ? sym_sh : '0;
        ev.limit_price     = (kind == KIND_ADD || kind == KIND_EXEC_PRICE ||
                              kind == KIND_REPLACE) ? px_sh : '0;
        return 1'b1;
    endfunction

    task automatic send_byte(input logic [7:0] b, output bit got, output order_event_t ev);
        int gap;
        if (!quiet_phase && !src_calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 7);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        got = decode_feed_byte(b, ev);
    endtask

    task automatic send_msg(input logic [7:0] mtype, input logic [15:0] blen,
                            input fill_t fill, input logic [7:0] fval,
                            input chk_t chk, input order_event_t listed);
        logic [7:0]   b;
        bit           got;
        order_event_t ev;
        send_byte(blen[15:8], got, ev);
        send_byte(blen[7:0], got, ev);
        for (int i = 0; i < blen; i++)
        begin
            case (fill)
                FILL_CONST: b = fval;
                FILL_RAMP:  b = i[7:0];
                default:    b = ((i == 19) && $urandom_range(0, 1)) ? CH_BUY
                                                                    : 8'($urandom_range(0, 255));
            endcase
            if (i == 0)
                b = mtype;
            send_byte(b, got, ev);
        end
        if (blen != 16'd0)
        begin
            if (chk == CHK_LISTED)
                pending_events.push_back(listed);
            else if (chk == CHK_MODEL && got)
                pending_events.push_back(ev);
        end
    endtask

    // sink side: random stall bursts, with calm stretches
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            sink_calm <= ~sink_calm;
        if (quiet_phase || sink_calm)
        begin
            m_axis_tready <= 1'b1;
            sink_hold     <= 0;
        end
        else if (sink_hold > 0)
        begin
            m_axis_tready <= 1'b0;
            sink_hold     <= sink_hold - 1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            m_axis_tready <= 1'b0;
            sink_hold     <= $urandom_range(0, 6);
        end
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        order_event_t want;
        logic [63:0]  exp_f[7];
        logic [63:0]  act_f[7];
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_events.size() == 0)
            begin
                $display("%0t: unexpected event transfer, actual kind %0d ref %0h",
                         $time, m_axis_tuser, m_axis_tdata[63:0]);
                mismatch_count++;
            end
            else
            begin
                want  = pending_events.pop_front();
                exp_f = '{64'(want.kind), want.order_ref, want.replacement_ref,
                          64'(want.is_buy), 64'(want.share_count), want.stock_symbol,
                          64'(want.limit_price)};
                act_f = '{64'(m_axis_tuser), m_axis_tdata[63:0], m_axis_tdata[127:64],
                          64'(m_axis_tdata[128]), 64'(m_axis_tdata[160:129]),
                          m_axis_tdata[224:161], 64'(m_axis_tdata[256:225])};
                for (int i = 0; i < 7; i++)
                    if (exp_f[i] !== act_f[i])
                    begin
                        $display("%0t: %s expected %0h actual %0h",
                                 $time, fld_name[i], exp_f[i], act_f[i]);
                        mismatch_count++;
                    end
            end
        end
    end

    initial
    begin
        logic [7:0]  mtype;
        logic [15:0] blen;
        int          need;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
            send_msg(dir_rows[r].mtype, dir_rows[r].blen, dir_rows[r].fill,
                     dir_rows[r].fval, dir_rows[r].chk, dir_rows[r].listed);

        // hold the stream until the event queue drains
        s_axis_tvalid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        @(posedge clk);

        while (rand_bytes < 450)
        begin
            quiet_phase = (rand_bytes >= 350);
            src_calm    = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 75)
            begin
                mtype = known_types[$urandom_range(0, 6)];
                need  = min_body(mtype);
                if ($urandom_range(0, 6) == 0)
                    blen = 16'($urandom_range(0, need - 1));
                else if ($urandom_range(0, 29) == 0)
                    blen = 16'($urandom_range(256, 300));
                else
                    blen = 16'(need + $urandom_range(0, 4));
            end
            else
            begin
                do
                    mtype = 8'($urandom_range(0, 255));
                while (min_body(mtype) != 0);
                blen = 16'($urandom_range(0, 40));
            end
            send_msg(mtype, blen, FILL_RAND, 8'h00, CHK_MODEL, NO_EVENT);
            rand_bytes += blen + 2;
        end

        s_axis_tvalid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[order_feed_message_parser_top.f]
hw/rtl/ofp_pkg.sv
hw/rtl/ofp_front.sv
hw/rtl/ofp_queue.sv
hw/rtl/ofp_back.sv
hw/rtl/order_feed_message_parser_top.sv
dv/tb_order_feed_message_parser_top.sv
